@@ rtl/core/sbd_pkg.sv @@
package sbd_pkg;

   // Block sizing
   localparam int NUM_LEVELS    = 2;
   localparam int LEVEL_SLOTS   = 2;
   localparam int TIMER_BITS    = 16;
   localparam int DELAY_BITS    = 16;
   localparam int STATE_BITS    = 2;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   // Word opcodes
   typedef enum logic {
      OP_EVENT = 1'b0,
      OP_TICK  = 1'b1
   } sbd_op_type;

   // Backoff state per level
   typedef enum logic [STATE_BITS-1:0] {
      ST_QUIET = 2'd0,
      ST_SHORT = 2'd1,
      ST_LONG  = 2'd2
   } sbd_state_type;

   // Register indexes on the CSR port
   typedef enum logic [2:0] {
      REG_INIT  = 3'd0,
      REG_SHORT = 3'd1,
      REG_LONG  = 3'd2,
      REG_LEARN = 3'd3,
      REG_HOLD  = 3'd4
   } sbd_reg_type;

   typedef logic [TIMER_BITS-1:0] sbd_timer_type;
   typedef logic [DELAY_BITS-1:0] sbd_delay_type;

   // Delay settings shared by all levels
   typedef struct packed {
      sbd_delay_type init_wait;
      sbd_delay_type short_wait;
      sbd_delay_type long_wait;
      sbd_delay_type learn_time;
      sbd_delay_type holddown;
   } sbd_cfg_type;

   // Per-level command for one step
   typedef struct packed {
      logic evt;
      logic tick;
   } sbd_lvl_cmd_type;

   // Per-level status after one step
   typedef struct packed {
      sbd_state_type state;
      logic          run;
      sbd_delay_type wait_ms;
      logic          armed;
   } sbd_lvl_stat_type;

   // Load a delay into a timer, saturating when the timer is narrower
   function automatic sbd_timer_type load_timer(input sbd_delay_type delay);
      logic [31:0] wide;
      wide = 32'(delay);
      if ((wide >> TIMER_BITS) != 32'd0) begin
         load_timer = '1;
      end else begin
         load_timer = TIMER_BITS'(wide);
      end
   endfunction

endpackage

@@ rtl/core/sbd_if.sv @@
interface sbd_req_if;
   logic valid;
   logic ready;
   logic opcode;
   logic level_sel;

   modport source (output valid, opcode, level_sel, input ready);
   modport sink (input valid, opcode, level_sel, output ready);
endinterface

interface sbd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  state_lvl1;
   logic [1:0]  state_lvl2;
   logic        run_spf_lvl1;
   logic        run_spf_lvl2;
   logic [15:0] chosen_wait_ms;
   logic        spf_armed;

   modport source (output valid, state_lvl1, state_lvl2, run_spf_lvl1, run_spf_lvl2,
                   chosen_wait_ms, spf_armed, input ready);
   modport sink (input valid, state_lvl1, state_lvl2, run_spf_lvl1, run_spf_lvl2,
                 chosen_wait_ms, spf_armed, output ready);
endinterface

@@ rtl/core/sbd_level.sv @@
module sbd_level (
   input  logic                      clock,
   input  logic                      reset,
   input  sbd_pkg::sbd_cfg_type      cfg,
   input  sbd_pkg::sbd_lvl_cmd_type  cmd,
   output sbd_pkg::sbd_lvl_stat_type stat
);
   import sbd_pkg::*;

   sbd_state_type state_ff, state_in;
   logic          spf_pend_ff, spf_pend_in;
   sbd_timer_type spf_rem_ff, spf_rem_in;
   logic          hold_armed_ff, hold_armed_in;
   sbd_timer_type hold_rem_ff, hold_rem_in;
   logic          learn_armed_ff, learn_armed_in;
   sbd_timer_type learn_rem_ff, learn_rem_in;

   sbd_delay_type wait_sel;
   logic          spf_fire;
   logic          learn_fire;
   logic          hold_fire;
   logic          spf_arm;

   // Timers fire on a tick when their count is down to one or zero
   assign spf_fire   = cmd.tick && spf_pend_ff && (spf_rem_ff <= TIMER_BITS'(1));
   assign learn_fire = cmd.tick && learn_armed_ff && (learn_rem_ff <= TIMER_BITS'(1));
   assign hold_fire  = cmd.tick && hold_armed_ff && (hold_rem_ff <= TIMER_BITS'(1));
   assign spf_arm    = cmd.evt && !spf_pend_ff;

   // Pick the SPF wait from the current state; the spare code acts as long wait
   always_comb begin
      unique case (state_ff)
         ST_QUIET: wait_sel = cfg.init_wait;
         ST_SHORT: wait_sel = cfg.short_wait;
         default:  wait_sel = cfg.long_wait;
      endcase
   end

   // Next backoff state: holddown expiry wins over learn expiry
   always_comb begin
      state_in = state_ff;
      priority if (cmd.evt && (state_ff == ST_QUIET)) begin
         state_in = ST_SHORT;
      end else if (hold_fire) begin
         state_in = ST_QUIET;
      end else if (learn_fire) begin
         state_in = ST_LONG;
      end else begin
         state_in = state_ff;
      end
   end

   // Timer updates
   always_comb begin
      spf_pend_in    = spf_pend_ff;
      spf_rem_in     = spf_rem_ff;
      hold_armed_in  = hold_armed_ff;
      hold_rem_in    = hold_rem_ff;
      learn_armed_in = learn_armed_ff;
      learn_rem_in   = learn_rem_ff;
      if (cmd.evt) begin
         if (state_ff == ST_QUIET) begin
            learn_armed_in = 1'b1;
            learn_rem_in   = load_timer(cfg.learn_time);
         end
         hold_armed_in = 1'b1;
         hold_rem_in   = load_timer(cfg.holddown);
         if (spf_arm) begin
            spf_pend_in = 1'b1;
            spf_rem_in  = load_timer(wait_sel);
         end
      end else if (cmd.tick) begin
         // SPF timer
         if (spf_fire) begin
            spf_pend_in = 1'b0;
            spf_rem_in  = '0;
         end else if (spf_pend_ff) begin
            spf_rem_in = spf_rem_ff - TIMER_BITS'(1);
         end
         // time-to-learn
         if (learn_fire) begin
            learn_armed_in = 1'b0;
            learn_rem_in   = '0;
         end else if (learn_armed_ff) begin
            learn_rem_in = learn_rem_ff - TIMER_BITS'(1);
         end
         // holddown, which also cancels time-to-learn
         if (hold_fire) begin
            hold_armed_in  = 1'b0;
            hold_rem_in    = '0;
            learn_armed_in = 1'b0;
            learn_rem_in   = '0;
         end else if (hold_armed_ff) begin
            hold_rem_in = hold_rem_ff - TIMER_BITS'(1);
         end
      end
   end

   // Status for the result word
   always_comb begin
      stat.state   = state_in;
      stat.run     = spf_fire;
      stat.wait_ms = cmd.evt ? wait_sel : '0;
      stat.armed   = spf_arm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_QUIET;
         spf_pend_ff    <= 1'b0;
         spf_rem_ff     <= '0;
         hold_armed_ff  <= 1'b0;
         hold_rem_ff    <= '0;
         learn_armed_ff <= 1'b0;
         learn_rem_ff   <= '0;
      end else begin
         state_ff       <= state_in;
         spf_pend_ff    <= spf_pend_in;
         spf_rem_ff     <= spf_rem_in;
         hold_armed_ff  <= hold_armed_in;
         hold_rem_ff    <= hold_rem_in;
         learn_armed_ff <= learn_armed_in;
         learn_rem_ff   <= learn_rem_in;
      end
   end

endmodule

@@ rtl/core/spf_backoff_delay_fsm.sv @@
// SPF backoff delay controller, three-state scheme for two routing levels.
// req_bus (valid/ready) carries one word per topology-change event or per
// millisecond tick: opcode 0 is an event for level_sel, opcode 1 a tick.
// rsp_bus (valid/ready) returns exactly one word per request: the state of
// both levels after the step, the SPF-run flags of a tick, and for an event
// the chosen wait and whether it armed a new SPF timer.
// A word accepted into the request register is stepped, and its result is
// loaded into the result register, which drives rsp_bus.
// Throughput: one word per cycle; the request register, the per-level
// update logic and the result register form a two-stage pipe.
// When the receiver holds rsp_bus.ready low the result word stays put and
// one more request is buffered; then req_bus.ready drops until it drains.
// Delay registers sit on the APB port at 4*index (init, short, long, learn,
// holddown); write them only while no word is in flight.
// Reset (synchronous) returns both levels to quiet, disarms all timers,
// zeros the delay registers and empties the pipe.
module spf_backoff_delay_fsm (
   input  logic                               clock,
   input  logic                               reset,
   sbd_req_if.sink                            req_bus,
   sbd_rsp_if.source                          rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [sbd_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  logic [sbd_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic [sbd_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                               pready
);
   import sbd_pkg::*;

   sbd_cfg_type      cfg_ff, cfg_in;
   sbd_reg_type      csr_idx;
   logic             csr_wr;

   logic             s1_valid_ff, s1_valid_in;
   logic             s1_opcode_ff;
   logic             s1_level_ff;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       state1_ff;
   logic [1:0]       state2_ff;
   logic             run1_ff;
   logic             run2_ff;
   sbd_delay_type    wait_ff;
   logic             armed_ff;

   logic             advance;
   logic             req_accept;
   logic             step;

   sbd_lvl_cmd_type  cmd [LEVEL_SLOTS];
   sbd_lvl_stat_type stat [LEVEL_SLOTS];

   // CSR port
   assign pready  = 1'b1;
   assign csr_idx = sbd_reg_type'(paddr[CSR_ADDR_BITS-1:2]);
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_INIT:  cfg_in.init_wait   = pwdata[DELAY_BITS-1:0];
            REG_SHORT: cfg_in.short_wait  = pwdata[DELAY_BITS-1:0];
            REG_LONG:  cfg_in.long_wait   = pwdata[DELAY_BITS-1:0];
            REG_LEARN: cfg_in.learn_time  = pwdata[DELAY_BITS-1:0];
            REG_HOLD:  cfg_in.holddown    = pwdata[DELAY_BITS-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_INIT:  prdata = CSR_DATA_BITS'(cfg_ff.init_wait);
         REG_SHORT: prdata = CSR_DATA_BITS'(cfg_ff.short_wait);
         REG_LONG:  prdata = CSR_DATA_BITS'(cfg_ff.long_wait);
         REG_LEARN: prdata = CSR_DATA_BITS'(cfg_ff.learn_time);
         REG_HOLD:  prdata = CSR_DATA_BITS'(cfg_ff.holddown);
         default:   prdata = '0;
      endcase
   end

   // Pipe control: advance whenever the result register is free or drained
   assign advance       = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_accept    = req_bus.valid && req_bus.ready;
   assign step          = advance && s1_valid_ff;

   assign s1_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   // Per-level units
   for (genvar g = 0; g < LEVEL_SLOTS; g++) begin : g_level
      if (g < NUM_LEVELS) begin : g_used
         always_comb begin
            cmd[g].evt  = step && (s1_opcode_ff == OP_EVENT) && (s1_level_ff == 1'(g));
            cmd[g].tick = step && (s1_opcode_ff == OP_TICK);
         end

         sbd_level u_level (
            .clock (clock),
            .reset (reset),
            .cfg   (cfg_ff),
            .cmd   (cmd[g]),
            .stat  (stat[g])
         );
      end else begin : g_unused
         // Absent level: never steps, reads as quiet
         assign cmd[g]  = '0;
         assign stat[g] = '0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request register
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_opcode_ff <= req_bus.opcode;
         s1_level_ff  <= req_bus.level_sel;
      end
   end

   // Result register: hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         state1_ff <= stat[0].state;
         state2_ff <= stat[1].state;
         run1_ff   <= stat[0].run;
         run2_ff   <= stat[1].run;
         wait_ff   <= stat[s1_level_ff].wait_ms;
         armed_ff  <= stat[s1_level_ff].armed;
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.state_lvl1     = state1_ff;
   assign rsp_bus.state_lvl2     = state2_ff;
   assign rsp_bus.run_spf_lvl1   = run1_ff;
   assign rsp_bus.run_spf_lvl2   = run2_ff;
   assign rsp_bus.chosen_wait_ms = wait_ff;
   assign rsp_bus.spf_armed      = armed_ff;

endmodule

@@ rtl/core/sbd_checker.sv @@
module sbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  state_lvl1,
   input logic [1:0]  state_lvl2,
   input logic        run_spf_lvl1,
   input logic        run_spf_lvl2,
   input logic [15:0] chosen_wait_ms,
   input logic        spf_armed
);

   // A stalled result word stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // A stalled result word keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(state_lvl1) && $stable(state_lvl2)
         && $stable(run_spf_lvl1) && $stable(run_spf_lvl2)
         && $stable(chosen_wait_ms) && $stable(spf_armed))
      else $error("result word changed while stalled");

   // Reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A fresh result comes from an accepted word, via the request and result registers
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("result word without a matching request");

   // A tick reports runs but never a wait or an arming
   a_tick_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (run_spf_lvl1 || run_spf_lvl2) |-> !spf_armed && (chosen_wait_ms == 16'd0))
      else $error("SPF run reported together with event fields");

endmodule

bind spf_backoff_delay_fsm sbd_checker u_sbd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_bus.valid),
   .req_ready      (req_bus.ready),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .state_lvl1     (rsp_bus.state_lvl1),
   .state_lvl2     (rsp_bus.state_lvl2),
   .run_spf_lvl1   (rsp_bus.run_spf_lvl1),
   .run_spf_lvl2   (rsp_bus.run_spf_lvl2),
   .chosen_wait_ms (rsp_bus.chosen_wait_ms),
   .spf_armed      (rsp_bus.spf_armed)
);

@@ tb/spf_backoff_delay_fsm_test.sv @@
module spf_backoff_delay_fsm_test;
   import sbd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_WORDS  = 135;
   localparam int RANDOM_PHASES = 8;
   localparam int DRAIN_CYCLES = 4;

   // One result word as seen on the response channel
   typedef struct packed {
      logic [1:0]    state_lvl1;
      logic [1:0]    state_lvl2;
      logic          run_spf_lvl1;
      logic          run_spf_lvl2;
      sbd_delay_type chosen_wait_ms;
      logic          spf_armed;
   } backoff_status_type;

   // Tracks both levels' backoff state and queues the status each word should produce
   class backoff_tracker;
      sbd_cfg_type        delays;
      sbd_state_type      lvl_state [LEVEL_SLOTS];
      logic               spf_on    [LEVEL_SLOTS];
      sbd_timer_type      spf_left  [LEVEL_SLOTS];
      logic               hold_on   [LEVEL_SLOTS];
      sbd_timer_type      hold_left [LEVEL_SLOTS];
      logic               learn_on  [LEVEL_SLOTS];
      sbd_timer_type      learn_left[LEVEL_SLOTS];
      backoff_status_type status_due[$];
      int                 errors;
      int                 n_events;
      int                 n_ticks;
      int                 n_runs;
      int                 n_armed;
      int                 n_checked;

      function new();
         delays = '0;
         for (int i = 0; i < LEVEL_SLOTS; i++) begin
            lvl_state[i]  = ST_QUIET;
            spf_on[i]     = 1'b0;
            spf_left[i]   = '0;
            hold_on[i]    = 1'b0;
            hold_left[i]  = '0;
            learn_on[i]   = 1'b0;
            learn_left[i] = '0;
         end
      endfunction

      function void set_reg(sbd_reg_type idx, sbd_delay_type value);
         unique case (idx)
            REG_INIT:  delays.init_wait   = value;
            REG_SHORT: delays.short_wait  = value;
            REG_LONG:  delays.long_wait   = value;
            REG_LEARN: delays.learn_time  = value;
            REG_HOLD:  delays.holddown    = value;
            default: ;
         endcase
      endfunction

      // Fire when the count is down to 0 or 1, else step it down
      function logic timer_fires(inout sbd_timer_type left);
         if (left <= sbd_timer_type'(1)) begin
            left = '0;
            return 1'b1;
         end
         left = left - 1'b1;
         return 1'b0;
      endfunction

      function void predict_step(sbd_op_type op, logic lvl);
         backoff_status_type want;
         logic               run [LEVEL_SLOTS];
         int                 l;
         want = '0;
         l = int'(lvl);
         run[0] = 1'b0;
         run[1] = 1'b0;
         if (op == OP_EVENT) begin
            n_events++;
            // An event for an absent level changes nothing
            if (l < NUM_LEVELS) begin
               // Pick the wait from the level's state; quiet also starts time-to-learn
               unique case (lvl_state[l])
                  ST_QUIET: begin
                     want.chosen_wait_ms = delays.init_wait;
                     lvl_state[l]  = ST_SHORT;
                     learn_on[l]   = 1'b1;
                     learn_left[l] = load_timer(delays.learn_time);
                  end
                  ST_SHORT: want.chosen_wait_ms = delays.short_wait;
                  default:  want.chosen_wait_ms = delays.long_wait;
               endcase
               hold_on[l]   = 1'b1;
               hold_left[l] = load_timer(delays.holddown);
               // Arm the SPF timer only when no run is pending
               if (!spf_on[l]) begin
                  spf_on[l]      = 1'b1;
                  spf_left[l]    = load_timer(want.chosen_wait_ms);
                  want.spf_armed = 1'b1;
                  n_armed++;
               end
            end
         end else begin
            n_ticks++;
            // Per level: SPF first, then time-to-learn, then holddown
            for (int i = 0; i < NUM_LEVELS; i++) begin
               if (spf_on[i] && timer_fires(spf_left[i])) begin
                  spf_on[i] = 1'b0;
                  run[i]    = 1'b1;
                  n_runs++;
               end
               if (learn_on[i] && timer_fires(learn_left[i])) begin
                  learn_on[i]  = 1'b0;
                  lvl_state[i] = ST_LONG;
               end
               if (hold_on[i] && timer_fires(hold_left[i])) begin
                  hold_on[i]    = 1'b0;
                  learn_on[i]   = 1'b0;
                  learn_left[i] = '0;
                  lvl_state[i]  = ST_QUIET;
               end
            end
         end
         want.state_lvl1   = lvl_state[0];
         want.state_lvl2   = lvl_state[1];
         want.run_spf_lvl1 = run[0];
         want.run_spf_lvl2 = run[1];
         status_due.push_back(want);
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void compare_status(backoff_status_type got);
         backoff_status_type want;
         if (status_due.size() == 0) begin
            $error("result word arrived with no expectation waiting");
            errors++;
            return;
         end
         want = status_due.pop_front();
         n_checked++;
         compare_field("state_lvl1", 16'(want.state_lvl1), 16'(got.state_lvl1));
         compare_field("state_lvl2", 16'(want.state_lvl2), 16'(got.state_lvl2));
         compare_field("run_spf_lvl1", 16'(want.run_spf_lvl1), 16'(got.run_spf_lvl1));
         compare_field("run_spf_lvl2", 16'(want.run_spf_lvl2), 16'(got.run_spf_lvl2));
         compare_field("chosen_wait_ms", want.chosen_wait_ms, got.chosen_wait_ms);
         compare_field("spf_armed", 16'(want.spf_armed), 16'(got.spf_armed));
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic                     pready;

   sbd_req_if req_bus ();
   sbd_rsp_if rsp_bus ();

   backoff_tracker model = new();
   int             send_idle_pct;
   int             recv_stall_pct;
   int             hold_off_cycles;
   int             cycle_count;
   int             settings_used;

   spf_backoff_delay_fsm DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still due", cycle_count,
                  model.status_due.size());
         $display("** spf_backoff_delay_fsm: FAILED **");
         $finish;
      end
   end

   // Take result words, stalling at random or for a requested long stretch
   initial begin
      backoff_status_type got;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.state_lvl1, rsp_bus.state_lvl2, rsp_bus.run_spf_lvl1,
                    rsp_bus.run_spf_lvl2, rsp_bus.chosen_wait_ms, rsp_bus.spf_armed};
            model.compare_status(got);
         end
         if (hold_off_cycles > 0) begin
            hold_off_cycles = hold_off_cycles - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
         end
      end
   end

   // Offer one word; valid stays high on return so back-to-back words need no gap
   task automatic send_word(input sbd_op_type op, input logic lvl);
      while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= op;
      req_bus.level_sel <= lvl;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      model.predict_step(op, lvl);
   endtask

   // Drop valid and wait until every result word is back
   task automatic drain_words();
      req_bus.valid <= 1'b0;
      while (model.status_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Setup then access; leaves psel high for a following write
   task automatic write_reg(input sbd_reg_type idx, input sbd_delay_type value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_BITS'(4 * int'(idx));
      pwdata  <= CSR_DATA_BITS'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      model.set_reg(idx, value);
   endtask

   task automatic write_delays(input sbd_cfg_type cfg);
      write_reg(REG_INIT, cfg.init_wait);
      write_reg(REG_SHORT, cfg.short_wait);
      write_reg(REG_LONG, cfg.long_wait);
      write_reg(REG_LEARN, cfg.learn_time);
      write_reg(REG_HOLD, cfg.holddown);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      settings_used++;
   endtask

   function automatic sbd_cfg_type random_delays(input int top);
      sbd_cfg_type cfg;
      cfg.init_wait   = sbd_delay_type'($urandom_range(top, 0));
      cfg.short_wait  = sbd_delay_type'($urandom_range(top, 0));
      cfg.long_wait   = sbd_delay_type'($urandom_range(top, 0));
      cfg.learn_time  = sbd_delay_type'($urandom_range(top, 0));
      cfg.holddown    = sbd_delay_type'($urandom_range(top, 0));
      return cfg;
   endfunction

   initial begin
      sbd_cfg_type cfg;
      sbd_op_type  op;
      cycle_count     = 0;
      send_idle_pct   = 0;
      recv_stall_pct  = 0;
      hold_off_cycles = 0;
      settings_used   = 1;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.opcode    <= OP_EVENT;
      req_bus.level_sel <= 1'b0;
      psel              <= 1'b0;
      penable           <= 1'b0;
      pwrite            <= 1'b0;
      paddr             <= '0;
      pwdata            <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset delays of zero: every timer fires on the next tick
      send_word(OP_EVENT, 1'b0);
      send_word(OP_TICK, 1'b0);
      send_word(OP_EVENT, 1'b1);
      send_word(OP_TICK, 1'b1);
      drain_words();

      // Zero and one waits, an event while a run is pending, joint learn and holddown expiry
      cfg = '{init_wait: 16'd0, short_wait: 16'd1, long_wait: 16'd3,
              learn_time: 16'd2, holddown: 16'd2};
      write_delays(cfg);
      send_word(OP_EVENT, 1'b0);
      send_word(OP_EVENT, 1'b0);
      send_word(OP_TICK, 1'b0);
      send_word(OP_TICK, 1'b1);
      send_word(OP_EVENT, 1'b1);
      send_word(OP_TICK, 1'b0);
      send_word(OP_EVENT, 1'b1);
      send_word(OP_TICK, 1'b0);
      send_word(OP_EVENT, 1'b1);
      send_word(OP_EVENT, 1'b0);
      send_word(OP_EVENT, 1'b0);
      repeat (5) send_word(OP_TICK, 1'b1);
      drain_words();

      // Random phases over several delay settings and idle patterns
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0: cfg = random_delays(6);
            1: cfg = random_delays(20);
            2: cfg = '{init_wait: 16'd0, short_wait: 16'd1, long_wait: 16'd2,
                       learn_time: 16'd0, holddown: 16'd1};
            3: cfg = random_delays(40);
            4: cfg = random_delays(10);
            5: cfg = random_delays(6);
            6: begin
               cfg = random_delays(8);
               cfg.learn_time = 16'hFFFF;
               cfg.holddown   = 16'hFFFF;
            end
            default: cfg = '{init_wait: 16'hFFFF, short_wait: 16'hFFFF,
                             long_wait: 16'hFFFF, learn_time: 16'hFFFF,
                             holddown: 16'hFFFF};
         endcase
         write_delays(cfg);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 10; recv_stall_pct = 10; end
         endcase
         // Hold the receiver off while words keep coming, so the input stalls
         if (ph == 3) hold_off_cycles = 80;
         for (int n = 0; n < PHASE_WORDS; n++) begin
            op = ($urandom_range(99, 0) < 55) ? OP_TICK : OP_EVENT;
            send_word(op, 1'($urandom_range(1, 0)));
         end
         drain_words();
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (model.status_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (model.status_due.size() != 0) begin
         $error("%0d result words never arrived", model.status_due.size());
         model.errors++;
      end

      $display("Covered %0d events and %0d ticks under %0d delay settings;",
               model.n_events, model.n_ticks, settings_used);
      $display("%0d SPF timers armed, %0d runs reported, %0d words checked, %0d errors.",
               model.n_armed, model.n_runs, model.n_checked, model.errors);
      if (model.errors == 0) begin
         $display("** spf_backoff_delay_fsm: PASSED **");
      end else begin
         $display("** spf_backoff_delay_fsm: FAILED **");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/sbd_pkg.sv
rtl/core/sbd_if.sv
rtl/core/sbd_level.sv
rtl/core/spf_backoff_delay_fsm.sv
rtl/core/sbd_checker.sv
tb/spf_backoff_delay_fsm_test.sv
